>>> hdl/gaussian_trait_space_fitness_unit_assert.svh
// Assertion macros used by the checker of the fitness unit.
// Needs a clock named clk and an active high reset named rst in scope.
`ifndef GAUSSIAN_TRAIT_SPACE_FITNESS_UNIT_ASSERT_SVH
`define GAUSSIAN_TRAIT_SPACE_FITNESS_UNIT_ASSERT_SVH

// Condition in this cycle implies property in the same cycle.
`define GTSF_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Condition in this cycle implies property in the next cycle.
`define GTSF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

>>> hdl/gtsf_pkg.sv
// Types, constants and register indexes of the Gaussian trait-space fitness unit.
// No dependencies; used by every module of the block except gtsf_lane.
package gtsf_pkg;

  localparam int MAX_TRAITS_DEF = 4;
  localparam int TRAIT_INPUTS   = 4;
  localparam int Z_W            = 22;
  localparam logic [Z_W-1:0] Z_CAP = Z_W'(32'd32 << 16);
  localparam int EXP_W          = 17;
  localparam int FIFO_DEPTH     = 16;
  localparam int PIPE_LAT       = 10;

  localparam logic [2:0] CFG_ALPHA       = 3'd0;
  localparam logic [2:0] CFG_BASE        = 3'd1;
  localparam logic [2:0] CFG_INV_SIGMA   = 3'd2;
  localparam logic [2:0] CFG_TRAIT_COUNT = 3'd3;
  localparam logic [2:0] CFG_PERIOD_X    = 3'd4;
  localparam logic [2:0] CFG_PERIOD_Y    = 3'd5;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] trait_0;
    logic signed [15:0] trait_1;
    logic signed [15:0] trait_2;
    logic signed [15:0] trait_3;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic              is_last;
  } item_t;

  typedef struct packed {
    logic [15:0] fitness;
    logic        last_out;
  } result_t;

endpackage

>>> hdl/gtsf_lane.sv
// One trait lane: absolute trait difference to the focal value, then its square.
// Two register stages; no package dependencies.
module gtsf_lane (
  input  logic               clk,
  input  logic signed [15:0] trait,
  input  logic signed [15:0] focal,
  input  logic               active,
  output logic [31:0]        sq
);

  logic [16:0] diff;
  logic [16:0] neg_diff;
  logic [15:0] mag;
  logic [15:0] mag_q;

  always_comb begin
    diff     = {trait[15], trait} - {focal[15], focal};
    neg_diff = 17'd0 - diff;
    mag      = diff[16] ? neg_diff[15:0] : diff[15:0];
  end

  always_ff @(posedge clk) begin
    mag_q <= active ? mag : 16'd0;
    sq    <= 32'(mag_q) * 32'(mag_q);
  end

endmodule

>>> hdl/gtsf_exp.sv
// Pipelined exp(-z) approximation through powers of two, four register stages.
// Depends on gtsf_pkg for the exponent and result widths.
module gtsf_exp import gtsf_pkg::*; (
  input  logic             clk,
  input  logic [Z_W-1:0]   z,
  output logic [EXP_W-1:0] e
);

  logic [38:0] ymul;
  logic [6:0]  n_1, n_2, n_3;
  logic [15:0] f_1;
  logic [31:0] t1m, ffm, t2m;
  logic [15:0] t1_2, f2_2;
  logic [17:0] p_full;
  logic [16:0] p_3;
  logic [4:0]  nm1;
  logic [17:0] half, rounded, shifted;

  always_comb begin
    ymul    = 39'(z) * 39'd94548 + 39'd32768;
    t1m     = 32'(f_1) * 32'd44014 + 32'd32768;
    ffm     = 32'(f_1) * 32'(f_1);
    t2m     = 32'(f2_2) * 32'd11246 + 32'd32768;
    p_full  = 18'd65536 - 18'(t1_2) + 18'(t2m[31:16]);
    nm1     = 5'(n_3 - 7'd1);
    half    = 18'd1 << nm1;
    rounded = {1'b0, p_3} + half;
    shifted = rounded >> n_3[4:0];
  end

  always_ff @(posedge clk) begin
    n_1  <= ymul[38:32];
    f_1  <= ymul[31:16];
    n_2  <= n_1;
    t1_2 <= t1m[31:16];
    f2_2 <= ffm[31:16];
    n_3  <= n_2;
    p_3  <= p_full[16:0];
    if (n_3 > 7'd16) begin
      e <= '0;
    end else if (n_3 == 7'd0) begin
      e <= p_3;
    end else begin
      e <= shifted[16:0];
    end
  end

endmodule

>>> hdl/gaussian_trait_space_fitness_unit.sv
// Gaussian trait-space fitness unit with a toroidal spatial kernel.
// Throughput: one beat per cycle while item_stall is low.
// One lane per trait dimension, merged by an adder tree.
// A 16-entry output queue stalls input only when queued and in-flight results would fill it.
// Synchronous reset rst clears config (trait count 1), focal state, queue, pipeline valids.
module gaussian_trait_space_fitness_unit import gtsf_pkg::*; #(
  parameter int MAX_TRAITS = MAX_TRAITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SUM_W  = 32 + $clog2(MAX_TRAITS);
  localparam int SH_W   = SUM_W - 18;
  localparam int FULL_W = SUM_W + 31;
  localparam int ZF_W   = FULL_W - 25;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  logic signed [15:0] alpha;
  logic [30:0]        a2;
  logic [15:0]        base_fitness, inv_two_sigma_sq, period_x, period_y;
  logic [2:0]         trait_count;
  logic signed [31:0] asq;

  logic signed [15:0] focal_trait [MAX_TRAITS];
  logic [15:0]        focal_x, focal_y;
  logic signed [15:0] trait_in [TRAIT_INPUTS];
  logic [31:0]        lane_sq [MAX_TRAITS];

  logic               accept, load, eval, deq;
  logic [PIPE_LAT-1:0] vld, last;

  logic [15:0]        dx_a, dy_a;
  logic [31:0]        dx2_b, dy2_b;
  logic [SUM_W-1:0]   sum_comb, sum_c;
  logic [32:0]        p_c;
  logic [SH_W+30:0]   ph_d;
  logic [48:0]        pl_d, pz_d;
  logic [FULL_W-1:0]  full;
  logic [Z_W-1:0]     zt_e, zs_e;
  logic [EXP_W-1:0]   et, es;
  logic [12:0]        eq;
  logic [17:0]        eq_sum;
  logic [17:0]        t_j;
  logic [EXP_W-1:0]   es_j;
  logic [34:0]        fit_prod;
  result_t            fit_res;

  result_t            queue [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fcnt, occ;

  function automatic logic [15:0] wrap_dist(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] period);
    logic [15:0] d;
    logic [16:0] w;
    logic [16:0] nw;
    begin
      d = (a > b) ? a - b : b - a;
      if ({d, 1'b0} > {1'b0, period}) begin
        w  = {1'b0, d} - {1'b0, period};
        nw = 17'd0 - w;
        d  = w[16] ? nw[15:0] : w[15:0];
      end
      wrap_dist = d;
    end
  endfunction

  function automatic logic signed [31:0] alpha_write_value(input logic [15:0] v);
    begin
      alpha_write_value = $signed(v) * $signed(v);
    end
  endfunction

  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign load       = accept && !item.mode;
  assign eval       = accept && item.mode;
  assign deq        = result_valid && !result_stall;
  assign item_stall = (occ == CNT_W'(FIFO_DEPTH));
  assign asq        = alpha_write_value(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha            <= '0;
      a2               <= '0;
      base_fitness     <= '0;
      inv_two_sigma_sq <= '0;
      trait_count      <= 3'd1;
      period_x         <= '0;
      period_y         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA: begin
          alpha <= $signed(cfg_data);
          a2    <= asq[30:0];
        end
        CFG_BASE:        base_fitness     <= cfg_data;
        CFG_INV_SIGMA:   inv_two_sigma_sq <= cfg_data;
        CFG_TRAIT_COUNT: trait_count      <= cfg_data[2:0];
        CFG_PERIOD_X:    period_x         <= cfg_data;
        CFG_PERIOD_Y:    period_y         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign trait_in[0] = item.trait_0;
  assign trait_in[1] = item.trait_1;
  assign trait_in[2] = item.trait_2;
  assign trait_in[3] = item.trait_3;

  for (genvar j = 0; j < MAX_TRAITS; j++) begin : g_lane
    logic signed [15:0] lane_trait;
    if (j < TRAIT_INPUTS) begin : g_in
      assign lane_trait = trait_in[j];
    end else begin : g_zero
      assign lane_trait = '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        focal_trait[j] <= '0;
      end else if (load) begin
        focal_trait[j] <= lane_trait;
      end
    end

    gtsf_lane u_lane (
      .clk    (clk),
      .trait  (lane_trait),
      .focal  (focal_trait[j]),
      .active (int'(trait_count) > j),
      .sq     (lane_sq[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= '0;
      focal_y <= '0;
    end else if (load) begin
      focal_x <= item.pos_x;
      focal_y <= item.pos_y;
    end
  end

  always_comb begin
    sum_comb = '0;
    for (int j = 0; j < MAX_TRAITS; j++) begin
      sum_comb = sum_comb + SUM_W'(lane_sq[j]);
    end
    full = {ph_d, 18'd0} + FULL_W'(pl_d);
  end

  always_ff @(posedge clk) begin
    dx_a  <= wrap_dist(focal_x, item.pos_x, period_x);
    dy_a  <= wrap_dist(focal_y, item.pos_y, period_y);
    dx2_b <= 32'(dx_a) * 32'(dx_a);
    dy2_b <= 32'(dy_a) * 32'(dy_a);
    sum_c <= sum_comb;
    p_c   <= 33'(dx2_b) + 33'(dy2_b);
    ph_d  <= (SH_W+31)'(sum_c[SUM_W-1:18]) * (SH_W+31)'(a2);
    pl_d  <= 49'(sum_c[17:0]) * 49'(a2);
    pz_d  <= 49'(p_c) * 49'(inv_two_sigma_sq);
    zt_e  <= (full[FULL_W-1:25] > ZF_W'(Z_CAP)) ? Z_CAP : full[25+Z_W-1:25];
    zs_e  <= (pz_d[48:16] > 33'(Z_CAP)) ? Z_CAP : pz_d[16+Z_W-1:16];
  end

  gtsf_exp u_exp_trait (
    .clk (clk),
    .z   (zt_e),
    .e   (et)
  );

  gtsf_exp u_exp_space (
    .clk (clk),
    .z   (zs_e),
    .e   (es)
  );

  always_comb begin
    eq_sum = 18'(et) + 18'd8;
    eq     = eq_sum[16:4];
  end

  always_ff @(posedge clk) begin
    if (alpha < 0) begin
      t_j <= 18'(base_fitness) + 18'd4096 - 18'(eq);
    end else begin
      t_j <= 18'(base_fitness) + 18'(eq);
    end
    es_j <= es;
  end

  always_comb begin
    fit_prod         = 35'(t_j) * 35'(es_j) + 35'd32768;
    fit_res.fitness  = (fit_prod[34:16] > 19'd65535) ? 16'hFFFF : fit_prod[31:16];
    fit_res.last_out = last[PIPE_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], eval};
    end
    last <= {last[PIPE_LAT-2:0], item.is_last};
  end

  always_ff @(posedge clk) begin
    if (vld[PIPE_LAT-1]) begin
      queue[wr_ptr] <= fit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
      occ    <= '0;
    end else begin
      if (vld[PIPE_LAT-1]) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fcnt <= fcnt + CNT_W'(vld[PIPE_LAT-1]) - CNT_W'(deq);
      occ  <= occ + CNT_W'(eval) - CNT_W'(deq);
    end
  end

  assign result_valid = (fcnt != '0);
  assign result       = queue[rd_ptr];

endmodule

>>> hdl/gtsf_checker.sv
// Port-level checker for the fitness unit, bound to the top level.
// Depends on gtsf_pkg and the assertion macro header.
`include "gaussian_trait_space_fitness_unit_assert.svh"

module gtsf_checker import gtsf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result,
  input logic    cfg_valid,
  input logic    cfg_ready
);

  // A result waiting on a stalled beat keeps its value.
  `GTSF_ASSERT_NEXT(a_result_hold, !rst && result_valid && result_stall, rst || (result_valid && $stable(result)), "stalled result changed")

  // Reset empties the output queue.
  `GTSF_ASSERT_NEXT(a_reset_empty, rst, !result_valid, "result valid right after reset")

  // The input stalls only when the queue already holds results.
  `GTSF_ASSERT_IMPL(a_stall_full, item_stall, result_valid, "input stalled with empty output")

  // A first result after an empty queue comes from an earlier accepted evaluation beat.
  `GTSF_ASSERT_IMPL(a_result_source, $rose(result_valid), $past(item_valid && !item_stall && item.mode, 11), "result without a matching evaluation beat")

  // The configuration port never refuses a write.
  `GTSF_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind gaussian_trait_space_fitness_unit gtsf_checker u_gtsf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

>>> test/tb.sv
// Self-checking testbench for the Gaussian trait-space fitness unit.
// Predicts each fitness value in fixed point and compares it with the DUT output.
// Depends on gtsf_pkg and gaussian_trait_space_fitness_unit.
`timescale 1ns / 1ps

module tb;
  import gtsf_pkg::*;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item_bus;
  logic result_valid;
  logic result_stall;
  result_t result_bus;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  logic signed [15:0] alpha_reg;
  logic [15:0] base_reg;
  logic [15:0] inv_sigma_reg;
  logic [2:0] trait_count_reg;
  logic [15:0] period_x_reg;
  logic [15:0] period_y_reg;
  logic signed [15:0] focal_trait [4];
  logic [15:0] focal_x;
  logic [15:0] focal_y;

  result_t fitness_expected [$];
  int mismatches;
  int burst_left;
  int stall_style;

  gaussian_trait_space_fitness_unit DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_bus),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1000000);
    $display("tb failed");
    $finish;
  end

  function automatic longint unsigned exp_neg_q16(longint unsigned z);
    longint unsigned y, n, f, t1, f2, t2, p;
    y = (z * 94548 + 32768) >> 16;
    n = y >> 16;
    f = y & 64'hFFFF;
    if (n > 16) begin
      return 0;
    end
    t1 = (f * 44014 + 32768) >> 16;
    f2 = (f * f) >> 16;
    t2 = (f2 * 11246 + 32768) >> 16;
    p = 65536 - t1 + t2;
    if (n == 0) begin
      return p;
    end
    return (p + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic longint unsigned torus_dist_sq(logic [15:0] a, logic [15:0] b,
                                                    logic [15:0] period);
    longint d;
    d = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
    if (d * 2 > longint'(period)) begin
      d = d - longint'(period);
    end
    if (d < 0) begin
      d = -d;
    end
    return d * d;
  endfunction

  function automatic logic signed [15:0] trait_of(item_t it, int j);
    case (j)
      0: return it.trait_0;
      1: return it.trait_1;
      2: return it.trait_2;
      default: return it.trait_3;
    endcase
  endfunction

  function automatic result_t predict_fitness(item_t it);
    result_t r;
    int used;
    longint d;
    longint unsigned trait_sum, a2, zt, zs, et, es, eq, term, fit;
    used = (trait_count_reg > 4) ? 4 : int'(trait_count_reg);
    trait_sum = 0;
    for (int j = 0; j < used; j++) begin
      d = longint'(trait_of(it, j)) - longint'(focal_trait[j]);
      if (d < 0) begin
        d = -d;
      end
      trait_sum += d * d;
    end
    a2 = longint'(alpha_reg) * longint'(alpha_reg);
    zt = (trait_sum * a2) >> 25;
    if (zt > (64'd32 << 16)) begin
      zt = 64'd32 << 16;
    end
    et = exp_neg_q16(zt);
    eq = (et + 8) >> 4;
    if (alpha_reg < 0) begin
      term = base_reg + 4096 - eq;
    end else begin
      term = base_reg + eq;
    end
    if (term < base_reg) begin
      term = base_reg;
    end
    zs = ((torus_dist_sq(focal_x, it.pos_x, period_x_reg)
         + torus_dist_sq(focal_y, it.pos_y, period_y_reg)) * inv_sigma_reg) >> 16;
    if (zs > (64'd32 << 16)) begin
      zs = 64'd32 << 16;
    end
    es = exp_neg_q16(zs);
    fit = (term * es + 32768) >> 16;
    if (fit > 65535) begin
      fit = 65535;
    end
    r.fitness = fit[15:0];
    r.last_out = it.is_last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (fitness_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result fitness=%0d last=%0b", result_bus.fitness,
                   result_bus.last_out);
        end
      end else begin
        if (result_bus !== fitness_expected[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected fitness=%0d last=%0b, got fitness=%0d last=%0b",
                     fitness_expected[0].fitness, fitness_expected[0].last_out,
                     result_bus.fitness, result_bus.last_out);
          end
        end
        void'(fitness_expected.pop_front());
      end
    end
  end

  // The receiver changes its stall style at random times.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      stall_style <= $urandom_range(0, 3);
    end
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= ($urandom_range(0, 15) < 8);
    endcase
  end

  task automatic send_item(item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (item_stall);
    if (it.mode) begin
      fitness_expected.push_back(predict_fitness(it));
    end else begin
      focal_trait[0] = it.trait_0;
      focal_trait[1] = it.trait_1;
      focal_trait[2] = it.trait_2;
      focal_trait[3] = it.trait_3;
      focal_x = it.pos_x;
      focal_y = it.pos_y;
    end
  endtask

  task automatic drain;
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
    while (fitness_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALPHA: alpha_reg = value;
      CFG_BASE: base_reg = value;
      CFG_INV_SIGMA: inv_sigma_reg = value;
      CFG_TRAIT_COUNT: trait_count_reg = value[2:0];
      CFG_PERIOD_X: period_x_reg = value;
      CFG_PERIOD_Y: period_y_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] a, logic [15:0] b, logic [15:0] s, logic [15:0] tc,
                            logic [15:0] px, logic [15:0] py);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_BASE, b);
    write_reg(CFG_INV_SIGMA, s);
    write_reg(CFG_TRAIT_COUNT, tc);
    write_reg(CFG_PERIOD_X, px);
    write_reg(CFG_PERIOD_Y, py);
  endtask

  function automatic item_t make_item(logic m, logic signed [15:0] t0, logic signed [15:0] t1,
                                      logic signed [15:0] t2, logic signed [15:0] t3,
                                      logic [15:0] x, logic [15:0] y, logic last);
    item_t it;
    it.mode = m;
    it.trait_0 = t0;
    it.trait_1 = t1;
    it.trait_2 = t2;
    it.trait_3 = t3;
    it.pos_x = x;
    it.pos_y = y;
    it.is_last = last;
    return it;
  endfunction

  task automatic test_reset_state;
    send_item(make_item(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 1'b1));
    send_item(make_item(1'b1, 16'sd256, -16'sd5, 16'sd9, 16'sd1, 16'd300, 16'd7, 1'b0));
    drain();
  endtask

  task automatic test_directed;
    set_config(16'h0800, 16'd1000, 16'h0100, 16'd4, 16'h2000, 16'h1000);
    send_item(make_item(1'b0, 16'sd100, -16'sd100, 16'sd0, 16'sd50, 16'h0100, 16'h0F00, 1'b1));
    send_item(make_item(1'b1, 16'sd100, -16'sd100, 16'sd0, 16'sd50, 16'h0100, 16'h0F00, 1'b0));
    send_item(make_item(1'b1, 16'sd356, -16'sd100, 16'sd0, 16'sd50, 16'h1F00, 16'h0100, 1'b1));
    send_item(make_item(1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF,
                        16'h0000, 1'b0));
    send_item(make_item(1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF,
                        16'hFFFF, 1'b1));
    send_item(make_item(1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'h0000,
                        16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF,
                        16'hFFFF, 1'b0));
    drain();
    set_config(16'h8000, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_item(make_item(1'b1, 16'sd1000, 16'sd5, 16'sd0, 16'sd0, 16'h0000, 16'hFFFF, 1'b1));
    send_item(make_item(1'b1, 16'sh8000, 16'sd5, 16'sd0, 16'sd0, 16'h8000, 16'h7FFF, 1'b0));
    drain();
    set_config(16'hF800, 16'd300, 16'hFFFF, 16'd7, 16'h0400, 16'h0001);
    send_item(make_item(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0010, 16'h0010, 1'b0));
    send_item(make_item(1'b1, 16'sd3, -16'sd2, 16'sd1, 16'sd4, 16'h03F0, 16'h0011, 1'b1));
    send_item(make_item(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0010, 16'h0010, 1'b0));
    drain();
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    send_item(make_item(1'b1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h0210, 16'h0012, 1'b1));
    drain();
    set_config(16'h7FFF, 16'd0, 16'h0001, 16'd5, 16'hFFFF, 16'h0000);
    send_item(make_item(1'b1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 16'h0000, 1'b0));
    drain();
  endtask

  function automatic logic signed [15:0] near_focal(logic signed [15:0] f, int spread);
    return f + 16'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_phase(int count, int spread);
    item_t it;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      it = item_t'({$urandom, $urandom, $urandom, $urandom});
      if (pick < 80) begin
        it.mode = 1'b1;
        it.trait_0 = near_focal(focal_trait[0], spread);
        it.trait_1 = near_focal(focal_trait[1], spread);
        it.trait_2 = near_focal(focal_trait[2], spread);
        it.trait_3 = near_focal(focal_trait[3], spread);
        it.pos_x = focal_x + 16'($urandom_range(0, 8 * spread));
        it.pos_y = focal_y - 16'($urandom_range(0, 8 * spread));
      end else if (pick < 92) begin
        it.mode = 1'b0;
      end
      send_item(it);
      if (k == count / 2 && $urandom_range(0, 1) == 0) begin
        drain();
      end
    end
    drain();
  endtask

  task automatic test_random;
    for (int p = 0; p < 6; p++) begin
      set_config(16'($urandom), 16'($urandom),
                 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64)),
                 16'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
      random_phase(200, 1 << $urandom_range(1, 10));
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item_bus = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_style = 0;
    burst_left = 0;
    mismatches = 0;
    alpha_reg = '0;
    base_reg = '0;
    inv_sigma_reg = '0;
    trait_count_reg = 3'd1;
    period_x_reg = '0;
    period_y_reg = '0;
    for (int j = 0; j < 4; j++) begin
      focal_trait[j] = '0;
    end
    focal_x = '0;
    focal_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_directed();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/gtsf_pkg.sv
hdl/gtsf_lane.sv
hdl/gtsf_exp.sv
hdl/gaussian_trait_space_fitness_unit.sv
hdl/gtsf_checker.sv
test/tb.sv
